FILE: rtl/core/wicf_pkg.sv
// Shared types and constants for the weighted index by cumulative fraction block.
// Depends on nothing; imported by the top level.
`default_nettype none

package wicf_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_ENTRIES_DEF = 64;
  localparam int unsigned WEIGHT_BITS_DEF = 16;

  // Fixed field widths of the stream payloads.
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned FRAC_W   = 17;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned Q16_SH   = 16;

  localparam logic [FRAC_W-1:0] Q16_ONE = FRAC_W'(32'h0001_0000);

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 8;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

endpackage

`default_nettype wire

FILE: rtl/core/wicf_ptab.sv
// Prefix-sum table: one write port and one read port with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module wicf_ptab #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 22,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [ADDR_W-1:0] wr_addr_i,
  input  wire logic [DATA_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: rtl/core/weighted_index_by_cumulative_fraction_top.sv
// Weighted index by cumulative fraction: weight loads build a prefix-sum table,
// queries scan it with one shared comparator. Depends on wicf_pkg and wicf_ptab.
// Loads produce no transfer. A query scans the table one entry per cycle and reports the first
// index whose prefix sum reaches the fraction of the total, or goes straight to the result on an
// empty table or a zero total; the input waits until the result register takes it.
// Asynchronous active-low reset empties the table; the output holds no transfer.
`default_nettype none

module weighted_index_by_cumulative_fraction_top
  import wicf_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [0] first, [16:1] weight, [33:17] fraction, [39:34] zero
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [0] kind
  input  wire logic                 s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [5:0] index, [6] found, [7] zero
  output logic      [M_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned EFF_W = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int unsigned AW    = $clog2(MAX_ENTRIES);
  localparam int unsigned CW    = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned SUM_W = EFF_W + AW;
  localparam int unsigned PROD_W = SUM_W + FRAC_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q;
  logic [SUM_W-1:0]   total_q;
  logic [PROD_W-1:0]  lhs_q;
  logic [CW-1:0]      addr_q;
  logic               rd_vld_q;
  logic [AW-1:0]      rd_idx_q;
  logic               res_found_q;
  logic [AW-1:0]      res_idx_q;
  logic               out_vld_q;
  logic               out_found_q;
  logic [INDEX_W-1:0] out_idx_q;

  logic                 in_xfer;
  kind_e                kind;
  logic                 first;
  logic [EFF_W-1:0]     weight_eff;
  logic [FRAC_W-1:0]    frac_raw;
  logic [FRAC_W-1:0]    frac_sat;
  logic [CW-1:0]        base_cnt;
  logic [SUM_W-1:0]     base_tot;
  logic [SUM_W-1:0]     new_tot;
  logic                 load_ok;
  logic                 wr_en;
  logic                 issue;
  logic [SUM_W-1:0]     rd_data;
  logic [PROD_W-1:0]    rhs;
  logic                 hit;
  logic                 last_seen;
  logic [AW+INDEX_W-1:0] res_idx_ext;
  logic                 out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  assign kind       = kind_e'(s_axis_tuser_i);
  assign first      = s_axis_tdata_i[0];
  assign weight_eff = s_axis_tdata_i[EFF_W:1];
  assign frac_raw   = s_axis_tdata_i[FRAC_W+WEIGHT_W:WEIGHT_W+1];
  assign frac_sat   = (frac_raw > Q16_ONE) ? Q16_ONE : frac_raw;

  // A load marked first restarts the table before its own weight is stored.
  assign base_cnt = first ? '0 : count_q;
  assign base_tot = first ? '0 : total_q;
  assign load_ok  = (base_cnt < CW'(MAX_ENTRIES));
  assign new_tot  = base_tot + SUM_W'(weight_eff);
  assign wr_en    = in_xfer && (kind == KIND_LOAD) && load_ok;

  // The scan issues one read per cycle and compares the entry read the cycle before.
  assign issue = (state_q == ST_SCAN) && (addr_q < count_q);

  wicf_ptab #(
    .DEPTH  (MAX_ENTRIES),
    .DATA_W (SUM_W),
    .ADDR_W (AW)
  ) u_ptab (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (base_cnt[AW-1:0]),
    .wr_data_i (new_tot),
    .rd_en_i   (issue),
    .rd_addr_i (addr_q[AW-1:0]),
    .rd_data_o (rd_data)
  );

  assign rhs       = {PROD_W'(rd_data)} << Q16_SH;
  assign hit       = rd_vld_q && (lhs_q <= rhs);
  assign last_seen = rd_vld_q && ((CW'(rd_idx_q) + CW'(1)) == count_q);

  assign res_idx_ext = {{INDEX_W{1'b0}}, res_idx_q};
  assign out_free    = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      lhs_q       <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
      out_vld_q   <= 1'b0;
      out_found_q <= 1'b0;
      out_idx_q   <= '0;
    end else begin
      // The done step reloads the result register itself when it is free.
      if (out_vld_q && m_axis_tready_i && (state_q != ST_DONE)) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          rd_vld_q <= 1'b0;
          addr_q   <= '0;
          if (in_xfer) begin
            unique case (kind)
              KIND_LOAD: begin
                if (load_ok) begin
                  count_q <= base_cnt + CW'(1);
                  total_q <= new_tot;
                end
              end
              KIND_QUERY: begin
                lhs_q <= PROD_W'(frac_sat) * PROD_W'(total_q);
                if ((count_q == '0) || (total_q == '0)) begin
                  res_found_q <= 1'b0;
                  res_idx_q   <= '0;
                  state_q     <= ST_DONE;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          rd_vld_q <= issue;
          rd_idx_q <= addr_q[AW-1:0];
          if (issue) begin
            addr_q <= addr_q + CW'(1);
          end
          if (hit) begin
            res_found_q <= 1'b1;
            res_idx_q   <= rd_idx_q;
            state_q     <= ST_DONE;
          end else if (last_seen) begin
            res_found_q <= 1'b0;
            res_idx_q   <= '0;
            state_q     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_found_q <= res_found_q;
            out_idx_q   <= res_idx_ext[INDEX_W-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_found_q, out_idx_q};

`ifndef SYNTHESIS
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> ((count_q != '0) && (total_q != '0)))
    else $error("table scan running on an empty table");

  a_empty_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (total_q == '0))
    else $error("nonzero total with no stored entries");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCAN) && rd_vld_q) |-> (CW'(rd_idx_q) < count_q))
    else $error("compared an entry beyond the stored count");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_DONE))
    else $error("result transfer raised outside the done step");
`endif

endmodule

`default_nettype wire
